// ===== design/bilinear_upscale_2x_assert.svh =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler assertion macros
// Shared concurrent assertion forms for the checker of the upscaler.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_UPSCALE_2X_ASSERT_SVH
`define BILINEAR_UPSCALE_2X_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define BU2X_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BU2X_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler package
// Widths, register codes and the item record shared by the upscaler modules.
// ----------------------------------------------------------------------------
package bu2x_pkg;

  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W     = COL_W + 1;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OCOL_W    = 12;
  localparam int unsigned OROW_W    = 13;
  localparam int unsigned CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(2048);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = CFG_IDX_W'(0),
    REG_SRC_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_e;

  // One source pixel with its neighborhood, as handed to the emitter.
  typedef struct packed {
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] ul;
    logic [PIX_W-1:0] lf;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last_col;
    logic             last_row;
  } item_t;

endpackage

// ===== design/bu2x_if.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler channels
// Valid/ready stream interfaces for source pixels and result pixels.
// ----------------------------------------------------------------------------
interface bu2x_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bu2x_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface bu2x_res_if;
  logic                        valid;
  logic                        ready;
  logic [bu2x_pkg::PIX_W-1:0]  pixel_out;
  logic [bu2x_pkg::OCOL_W-1:0] out_col;
  logic [bu2x_pkg::OROW_W-1:0] out_row;
  logic                        run_last;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, input ready);
  modport sink (input valid, input pixel_out, input out_col, input out_row,
                input run_last, output ready);
endinterface

// ===== design/bu2x_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module bu2x_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while the port is not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bu2x_fetch.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler fetch stage
// Holds the configuration and raster counters, and reads and updates the
// line buffer for each source pixel.
// ----------------------------------------------------------------------------
module bu2x_fetch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bu2x_pix_if.sink                       pix_i,
  input  logic                           cfg_we_i,
  input  logic [bu2x_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bu2x_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                           item_valid_o,
  input  logic                           item_ready_i,
  output bu2x_pkg::item_t                item_o
);

  logic [bu2x_pkg::CFG_W-1:0] width_q, height_q;
  logic [bu2x_pkg::COL_W-1:0] col_q, col_d;
  logic [bu2x_pkg::ROW_W-1:0] row_q, row_d;
  logic [bu2x_pkg::PIX_W-1:0] left_q, prev_up_q;

  logic                       s1_valid_q, s1_valid_d;
  logic [bu2x_pkg::PIX_W-1:0] s1_p_q, s1_lf_q;
  logic [bu2x_pkg::COL_W-1:0] s1_col_q;
  logic [bu2x_pkg::ROW_W-1:0] s1_row_q;
  logic                       s1_lc_q, s1_lr_q;

  logic [bu2x_pkg::CMP_W-1:0] width_ext, eff_width, col_inc;
  logic [bu2x_pkg::ROW_W:0]   eff_height, row_inc;
  logic                       last_col, last_row;
  logic                       accept, advance;
  logic [bu2x_pkg::PIX_W-1:0] ram_rdata;
  logic [bu2x_pkg::PIX_W-1:0] up_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bu2x_pkg::WIDTH_RESET;
      height_q <= bu2x_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (bu2x_pkg::cfg_reg_e'(cfg_idx_i))
        bu2x_pkg::REG_SRC_WIDTH:  width_q  <= cfg_data_i;
        bu2x_pkg::REG_SRC_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero dimensions count as one; the width saturates at the buffer size.
  always_comb begin
    width_ext = bu2x_pkg::CMP_W'(width_q);
    if (width_ext == '0) begin
      eff_width = bu2x_pkg::CMP_W'(1);
    end else if (width_ext > bu2x_pkg::CMP_W'(bu2x_pkg::MAX_WIDTH)) begin
      eff_width = bu2x_pkg::CMP_W'(bu2x_pkg::MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    eff_height = (height_q == '0) ? (bu2x_pkg::ROW_W+1)'(1) : {1'b0, height_q};
    col_inc    = bu2x_pkg::CMP_W'(col_q) + bu2x_pkg::CMP_W'(1);
    row_inc    = {1'b0, row_q} + (bu2x_pkg::ROW_W+1)'(1);
    last_col   = (col_inc >= eff_width);
    last_row   = (row_inc >= eff_height);
  end

  assign advance     = s1_valid_q && item_ready_i;
  assign pix_i.ready = !s1_valid_q || item_ready_i;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[bu2x_pkg::ROW_W-1:0];
      end else begin
        col_d = col_inc[bu2x_pkg::COL_W-1:0];
      end
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      prev_up_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        left_q <= pix_i.pixel_in;
      end
      // The pixel above this one becomes the upper-left of the next one.
      if (advance) begin
        prev_up_q <= up_pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_p_q   <= pix_i.pixel_in;
      s1_lf_q  <= left_q;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_lc_q  <= last_col;
      s1_lr_q  <= last_row;
    end
  end

  // The old entry is read out and replaced by the new pixel in one access,
  // so a following pixel at the same column always sees the fresh value.
  bu2x_ram #(
    .WIDTH (bu2x_pkg::PIX_W),
    .DEPTH (bu2x_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept),
    .addr_i  (col_q),
    .wdata_i (pix_i.pixel_in),
    .rdata_o (ram_rdata)
  );

  // The first row has no row above it and gives it zero weight, so the
  // buffer entry, which may never have been written, is not passed on.
  assign up_pix = (s1_row_q == '0) ? '0 : ram_rdata;

  assign item_valid_o    = s1_valid_q;
  assign item_o.p        = s1_p_q;
  assign item_o.up       = up_pix;
  assign item_o.ul       = prev_up_q;
  assign item_o.lf       = s1_lf_q;
  assign item_o.col      = s1_col_q;
  assign item_o.row      = s1_row_q;
  assign item_o.last_col = s1_lc_q;
  assign item_o.last_row = s1_lr_q;

endmodule

// ===== design/bu2x_emit.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler emitter
// Steps through the output pixels completed by one source pixel, one per
// cycle unless stalled, row-major, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bu2x_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  bu2x_pkg::item_t item_i,
  bu2x_res_if.source      res_o
);

  // Position along one axis: odd coordinate left of the sample (3:1),
  // even coordinate at the sample (1:3), or the clamped border (0:4).
  typedef enum logic [1:0] {
    K_PREV = 2'd0,
    K_CUR  = 2'd1,
    K_EDGE = 2'd2
  } kind_e;

  localparam int unsigned SUM_W = bu2x_pkg::PIX_W + 5;
  localparam int unsigned XC_W  = bu2x_pkg::COL_W + 2;
  localparam int unsigned YC_W  = bu2x_pkg::ROW_W + 2;

  function automatic kind_e start_kind(input logic first);
    return first ? K_CUR : K_PREV;
  endfunction

  function automatic kind_e next_kind(input kind_e k);
    case (k)
      K_PREV:  return K_CUR;
      default: return K_EDGE;
    endcase
  endfunction

  function automatic logic [2:0] prev_weight(input kind_e k, input logic first);
    case (k)
      K_PREV:  return 3'd3;
      K_CUR:   return first ? 3'd0 : 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  logic            busy_q, busy_d;
  bu2x_pkg::item_t it_q;
  kind_e           kx_q, kx_d, ky_q, ky_d;

  logic                        res_valid_q, res_valid_d;
  logic [bu2x_pkg::PIX_W-1:0]  pix_q;
  logic [bu2x_pkg::OCOL_W-1:0] col_q;
  logic [bu2x_pkg::OROW_W-1:0] row_q;
  logic                        last_q;

  logic       x_first, y_first;
  kind_e      x_start, x_end, y_end;
  logic       at_x_end, at_end, step, load;
  logic [2:0] wxp, wxc, wyp, wyc;
  logic [4:0] w_ul, w_up, w_lf, w_p;
  logic [SUM_W-1:0] sum;
  logic [XC_W-1:0]  x_full;
  logic [YC_W-1:0]  y_full;

  assign x_first  = (it_q.col == '0);
  assign y_first  = (it_q.row == '0);
  assign x_start  = start_kind(x_first);
  assign x_end    = it_q.last_col ? K_EDGE : K_CUR;
  assign y_end    = it_q.last_row ? K_EDGE : K_CUR;
  assign at_x_end = (kx_q == x_end);
  assign at_end   = at_x_end && (ky_q == y_end);

  assign step         = busy_q && (!res_valid_q || res_o.ready);
  assign item_ready_o = !busy_q || (step && at_end);
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    busy_d = busy_q;
    kx_d   = kx_q;
    ky_d   = ky_q;
    if (load) begin
      busy_d = 1'b1;
      kx_d   = start_kind(item_i.col == '0);
      ky_d   = start_kind(item_i.row == '0);
    end else if (step) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else if (at_x_end) begin
        kx_d = x_start;
        ky_d = next_kind(ky_q);
      end else begin
        kx_d = next_kind(kx_q);
      end
    end
  end

  always_comb begin
    wxp    = prev_weight(kx_q, x_first);
    wxc    = 3'd4 - wxp;
    wyp    = prev_weight(ky_q, y_first);
    wyc    = 3'd4 - wyp;
    w_ul   = 5'(wyp) * 5'(wxp);
    w_up   = 5'(wyp) * 5'(wxc);
    w_lf   = 5'(wyc) * 5'(wxp);
    w_p    = 5'(wyc) * 5'(wxc);
    sum    = SUM_W'(w_ul) * SUM_W'(it_q.ul) + SUM_W'(w_up) * SUM_W'(it_q.up)
           + SUM_W'(w_lf) * SUM_W'(it_q.lf) + SUM_W'(w_p) * SUM_W'(it_q.p)
           + SUM_W'(8);
    x_full = {1'b0, it_q.col, 1'b0} + XC_W'(kx_q) - XC_W'(1);
    y_full = {1'b0, it_q.row, 1'b0} + YC_W'(ky_q) - YC_W'(1);
  end

  assign res_valid_d = step ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      kx_q        <= K_PREV;
      ky_q        <= K_PREV;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      kx_q        <= kx_d;
      ky_q        <= ky_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      it_q <= item_i;
    end
    if (step) begin
      pix_q  <= sum[bu2x_pkg::PIX_W+3:4];
      col_q  <= bu2x_pkg::OCOL_W'(x_full);
      row_q  <= bu2x_pkg::OROW_W'(y_full);
      last_q <= at_end;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.pixel_out = pix_q;
  assign res_o.out_col   = col_q;
  assign res_o.out_row   = row_q;
  assign res_o.run_last  = last_q;

endmodule

// ===== design/bilinear_upscale_2x.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x image upscaler
// Path: fetch stage register, emitter item register, then the output register.
// Throughput: one result per cycle from the emitter unless the sink stalls; a pixel
// gives n = 1..9 results, four on average over an image.
// Reset: counters clear, width 2048, height 1; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bu2x_pix_if.sink                       pix_i,
  bu2x_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [bu2x_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bu2x_pkg::CFG_W-1:0]     cfg_data_i
);

  logic            item_valid;
  logic            item_ready;
  bu2x_pkg::item_t item;

  bu2x_fetch u_fetch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  bu2x_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_o        (res_o)
  );

endmodule

// ===== design/bu2x_checker.sv =====
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "bilinear_upscale_2x_assert.svh"

module bu2x_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [bu2x_pkg::PIX_W-1:0]  pixel_out_i,
  input logic [bu2x_pkg::OCOL_W-1:0] out_col_i,
  input logic [bu2x_pkg::OROW_W-1:0] out_row_i,
  input logic                        run_last_i
);

  `BU2X_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `BU2X_ASSERT(a_res_stable, clk_i, rst_ni, res_valid_i && !res_ready_i |=> $stable(pixel_out_i) && $stable(out_col_i) && $stable(out_row_i) && $stable(run_last_i), "result changed while stalled")
  // Results of one source pixel leave back to back once the sink is ready.
  `BU2X_ASSERT(a_run_cont, clk_i, rst_ni, res_valid_i && res_ready_i && !run_last_i |=> res_valid_i, "gap inside a run of results")
  `BU2X_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !res_valid_i, "result offered during reset")

endmodule

bind bilinear_upscale_2x bu2x_checker u_bu2x_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .pixel_out_i (res_o.pixel_out),
  .out_col_i   (res_o.out_col),
  .out_row_i   (res_o.out_row),
  .run_last_i  (res_o.run_last)
);

// ===== dv/bilinear_upscale_2x_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear 2x upscaler testbench
// Streams source images through the upscaler and compares every result
// pixel, with its coordinates and end-of-run flag, against a line-buffer
// predictor kept in step with each accepted transfer. Directed images cover
// reset sizes, degenerate sizes, interior weights and reshaping in the
// middle of an image. Random images follow, with random stalls on both
// channels except in the last part.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x_test;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [bu2x_pkg::PIX_W-1:0]  pix;
    logic [bu2x_pkg::OCOL_W-1:0] col;
    logic [bu2x_pkg::OROW_W-1:0] row;
    logic                        last;
  } up_pixel_t;

  // One output coordinate on an axis, with the weights of the previous and
  // the current source sample along that axis.
  typedef struct packed {
    logic [15:0] crd;
    logic [2:0]  w_prev;
    logic [2:0]  w_cur;
  } tap_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [bu2x_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [bu2x_pkg::CFG_W-1:0] cfg_data;

  bu2x_pix_if pix ();
  bu2x_res_if res ();

  bilinear_upscale_2x dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state.
  logic [bu2x_pkg::PIX_W-1:0] line_buf [bu2x_pkg::MAX_WIDTH];
  logic [bu2x_pkg::PIX_W-1:0] left_px;
  logic [bu2x_pkg::PIX_W-1:0] upleft_px;
  int unsigned                col_cnt;
  int unsigned                row_cnt;
  logic [bu2x_pkg::CFG_W-1:0] cfg_width;
  logic [bu2x_pkg::CFG_W-1:0] cfg_height;

  up_pixel_t   expected_pixels [$];
  up_pixel_t   want_px;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side back-pressure in bursts of random length.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      res.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result pixel at column %0d, row %0d",
               res.out_col, res.out_row);
        error_cnt++;
      end else begin
        want_px = expected_pixels.pop_front();
        if (res.pixel_out !== want_px.pix) begin
          $error("pixel_out: expected %0d, got %0d", want_px.pix, res.pixel_out);
          error_cnt++;
        end
        if (res.out_col !== want_px.col) begin
          $error("out_col: expected %0d, got %0d", want_px.col, res.out_col);
          error_cnt++;
        end
        if (res.out_row !== want_px.row) begin
          $error("out_row: expected %0d, got %0d", want_px.row, res.out_row);
          error_cnt++;
        end
        if (res.run_last !== want_px.last) begin
          $error("run_last: expected %0d, got %0d", want_px.last, res.run_last);
          error_cnt++;
        end
      end
    end
  end

  function automatic int unsigned tap_count(input int unsigned pos, input bit last);
    return ((pos == 0) ? 1 : 2) + (last ? 1 : 0);
  endfunction

  // Output coordinates completed by source index pos: 0 alone for the first
  // sample, else 2*pos-1 and 2*pos, plus 2*pos+1 past the last sample.
  function automatic tap_t axis_tap(input int unsigned pos, input int unsigned k);
    tap_t t;
    if (pos == 0) begin
      t.crd    = 16'(k);
      t.w_prev = 3'd0;
      t.w_cur  = 3'd4;
    end else begin
      t.crd = 16'(2 * pos - 1 + k);
      case (k)
        0: begin
          t.w_prev = 3'd3;
          t.w_cur  = 3'd1;
        end
        1: begin
          t.w_prev = 3'd1;
          t.w_cur  = 3'd3;
        end
        default: begin
          t.w_prev = 3'd0;
          t.w_cur  = 3'd4;
        end
      endcase
    end
    return t;
  endfunction

  task automatic predict_upscale(input logic [bu2x_pkg::PIX_W-1:0] px);
    int unsigned w_eff, h_eff, ny, nx, i, j, s;
    int unsigned wyp, wyc, wxp, wxc;
    bit last_c, last_r;
    logic [bu2x_pkg::PIX_W-1:0] up;
    tap_t ty, tx;
    up_pixel_t e;
    w_eff  = (cfg_width == 0) ? 1 :
             ((cfg_width > bu2x_pkg::MAX_WIDTH) ? bu2x_pkg::MAX_WIDTH : cfg_width);
    h_eff  = (cfg_height == 0) ? 1 : cfg_height;
    last_c = (col_cnt + 1 >= w_eff);
    last_r = (row_cnt + 1 >= h_eff);
    up     = (col_cnt < bu2x_pkg::MAX_WIDTH) ? line_buf[col_cnt] : '0;
    ny     = tap_count(row_cnt, last_r);
    nx     = tap_count(col_cnt, last_c);
    for (i = 0; i < ny; i++) begin
      for (j = 0; j < nx; j++) begin
        ty  = axis_tap(row_cnt, i);
        tx  = axis_tap(col_cnt, j);
        wyp = ty.w_prev;
        wyc = ty.w_cur;
        wxp = tx.w_prev;
        wxc = tx.w_cur;
        s = wyp * wxp * upleft_px + wyp * wxc * up
          + wyc * wxp * left_px + wyc * wxc * px + 8;
        e.pix  = bu2x_pkg::PIX_W'(s >> 4);
        e.col  = bu2x_pkg::OCOL_W'(tx.crd);
        e.row  = bu2x_pkg::OROW_W'(ty.crd);
        e.last = (i == ny - 1) && (j == nx - 1);
        expected_pixels.push_back(e);
      end
    end
    if (col_cnt < bu2x_pkg::MAX_WIDTH) line_buf[col_cnt] = px;
    upleft_px = up;
    left_px   = px;
    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : ((row_cnt + 1) & 32'hFFF);
    end else begin
      col_cnt++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the next pixel can follow back to back.
  task automatic send_pixel(input logic [bu2x_pkg::PIX_W-1:0] px);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      pix.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    pix.valid    = 1'b1;
    pix.pixel_in = px;
    do @(posedge clk_i); while (!pix.ready);
    predict_upscale(px);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    pix.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_image_size(input logic [bu2x_pkg::CFG_W-1:0] w,
                                input logic [bu2x_pkg::CFG_W-1:0] h);
    cfg_we   = 1'b1;
    cfg_idx  = bu2x_pkg::REG_SRC_WIDTH;
    cfg_data = w;
    @(negedge clk_i);
    cfg_idx  = bu2x_pkg::REG_SRC_HEIGHT;
    cfg_data = h;
    @(negedge clk_i);
    cfg_we     = 1'b0;
    cfg_width  = w;
    cfg_height = h;
  endtask

  function automatic logic [bu2x_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return bu2x_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Reset sizes, then a width cut below the current column of the open row.
  task automatic test_reset_config();
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    wait_idle();
    set_image_size(12'd2, 12'd1);
    send_pixel(8'hA5);
  endtask

  // Zero sizes act as one, so each pixel is an image of four copies; then 1x2.
  task automatic test_degenerate_sizes();
    wait_idle();
    set_image_size(12'd0, 12'd0);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    wait_idle();
    set_image_size(12'd1, 12'd2);
    send_pixel(8'hFF);
    send_pixel(8'h00);
  endtask

  task automatic test_interior_weights();
    logic [bu2x_pkg::PIX_W-1:0] img [9];
    int unsigned k;
    img = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd254, 8'd7, 8'd255, 8'd0, 8'd128};
    wait_idle();
    set_image_size(12'd3, 12'd3);
    for (k = 0; k < 9; k++) send_pixel(img[k]);
  endtask

  // Two rows of a five-row image, then the height drops below the open row.
  task automatic test_height_cut_mid_image();
    int unsigned k;
    wait_idle();
    set_image_size(12'd2, 12'd5);
    for (k = 0; k < 4; k++) send_pixel(random_pixel());
    wait_idle();
    set_image_size(12'd2, 12'd1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
  endtask

  task automatic test_random_images(input int unsigned item_goal, input bit with_idling);
    int unsigned sent, w, h, n, cut, k;
    bit shaped;
    sent         = 0;
    shaped       = 1'b0;
    src_idle_en  = with_idling;
    sink_idle_en = with_idling;
    while (sent < item_goal) begin
      // Complete an image left open by a reshape, under its new size.
      while (col_cnt != 0 || row_cnt != 0) begin
        send_pixel(random_pixel());
        sent++;
      end
      if (!shaped || $urandom_range(0, 2) != 0) begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        wait_idle();
        set_image_size(bu2x_pkg::CFG_W'(w), bu2x_pkg::CFG_W'(h));
        shaped = 1'b1;
      end
      n   = w * h;
      cut = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
      for (k = 0; k < cut; k++) send_pixel(random_pixel());
      sent += cut;
      if (cut < n) begin
        // The width only shrinks here, so no row reads buffer entries that
        // this image has not written.
        w = $urandom_range(1, w);
        h = $urandom_range(1, 6);
        wait_idle();
        set_image_size(bu2x_pkg::CFG_W'(w), bu2x_pkg::CFG_W'(h));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    pix.valid    = 1'b0;
    pix.pixel_in = '0;
    res.ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = bu2x_pkg::REG_SRC_WIDTH;
    cfg_data     = '0;
    error_cnt    = 0;
    cycle_cnt    = 0;
    stall_left   = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    left_px      = '0;
    upleft_px    = '0;
    col_cnt      = 0;
    row_cnt      = 0;
    cfg_width    = bu2x_pkg::WIDTH_RESET;
    cfg_height   = bu2x_pkg::HEIGHT_RESET;
    foreach (line_buf[k]) line_buf[k] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_degenerate_sizes();
    test_interior_weights();
    test_height_cut_mid_image();
    test_random_images(55, 1'b1);
    test_random_images(25, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bu2x_pkg.sv
design/bu2x_if.sv
design/bu2x_ram.sv
design/bu2x_fetch.sv
design/bu2x_emit.sv
design/bilinear_upscale_2x.sv
design/bu2x_checker.sv
dv/bilinear_upscale_2x_test.sv
